// ===== rtl/rcp_pkg.sv =====
// rcp_pkg: shared types, constants and helpers of the RDP cookie pre-read parser.
// Used by the channel interfaces and the parser top level; depends on nothing.
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int KEY_BYTES_DEF = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int LEN_W         = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd2;

  localparam logic [7:0] TPKT_VERSION = 8'd3;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CHAR_EQ      = 8'h3d;

  localparam logic [LEN_W-1:0] MIN_PKT_LEN = 16'd21;
  localparam logic [LEN_W-1:0] TAG_FIRST   = 16'd11;
  localparam logic [LEN_W-1:0] TAG_LAST    = 16'd17;

  typedef enum logic [2:0] {
    VERD_OK         = 3'd0,
    VERD_NOT_TPKT   = 3'd1,
    VERD_BAD_RSV    = 3'd2,
    VERD_TOO_SHORT  = 3'd3,
    VERD_NO_TAG     = 3'd4,
    VERD_BAD_COOKIE = 3'd5,
    VERD_DISABLED   = 3'd6
  } verdict_t;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_HDR  = 7'b0000010,
    PH_TAG  = 7'b0000100,
    PH_SKIP = 7'b0001000,
    PH_SCAN = 7'b0010000,
    PH_LF   = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       cookie_byte;
    logic             in_value;
    logic [2:0]       verdict;
    logic [LEN_W-1:0] cookie_len;
    logic             value_found;
    logic [LEN_W-1:0] value_len;
  } out_item_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  // Lower-case text of the tag "cookie:"
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h63;
      3'd1:    r = 8'h6f;
      3'd2:    r = 8'h6f;
      3'd3:    r = 8'h6b;
      3'd4:    r = 8'h69;
      3'd5:    r = 8'h65;
      3'd6:    r = 8'h3a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rcp_ifs.sv =====
// Channel interfaces of the RDP cookie pre-read parser: byte input, result output
// and configuration write. Depends on rcp_pkg.
`timescale 1ns / 1ps

interface rcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface rcp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [7:0]               cookie_byte;
  logic                     in_value;
  logic [2:0]               verdict;
  logic [rcp_pkg::LEN_W-1:0] cookie_len;
  logic                     value_found;
  logic [rcp_pkg::LEN_W-1:0] value_len;
  modport source (output valid, output kind, output cookie_byte, output in_value,
                  output verdict, output cookie_len, output value_found,
                  output value_len, input ready);
  modport sink   (input valid, input kind, input cookie_byte, input in_value,
                  input verdict, input cookie_len, input value_found,
                  input value_len, output ready);
endinterface

interface rcp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rcp_pkg::CFG_IDX_W-1:0]  index;
  logic [rcp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rdp_cookie_preread_parser_unit.sv =====
// Top level of the RDP cookie pre-read parser: byte-wise TPKT/X.224 header and
// cookie parse with key=value lookup. Depends on rcp_pkg and rcp_ifs.
`timescale 1ns / 1ps

// Usage:
//   in_ch  : one stream byte per request, with first marking byte 0 of a new
//            connection. Bytes before any first, or after a verdict, are dropped.
//   out_ch : cookie bytes (kind 0) and one final verdict (kind 1) per connection.
//   cfg_ch : register writes (enable, key_chars, key_len); always ready, write
//            only while the parser is idle.
// Timing: a taken byte's result, if any, is registered in the output register,
//   or in the skid entry if the output stalls; one byte per cycle while the skid
//   is empty, set by the single per-byte state update feeding the output register.
// Stall: the output register is backed by a one-entry skid buffer, so a byte is
//   still taken while a result waits; in_ch.ready drops only when the skid entry
//   is full, and rises again in the cycle after out_ch.ready returns.
// Reset (rst_n low, synchronous): parse state to idle, configuration registers
//   to zero, output and skid empty.

module rdp_cookie_preread_parser_unit #(
  parameter int KEY_BYTES = rcp_pkg::KEY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rcp_in_if.sink           in_ch,
  rcp_out_if.source        out_ch,
  rcp_cfg_if.sink          cfg_ch
);

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [3:0] KMAX = 4'(KEY_BYTES);
  localparam int LW = rcp_pkg::LEN_W;

  // configuration
  logic                   enable_r;
  logic [KEY_BYTES*8-1:0] key_chars_r;
  logic [3:0]             key_len_r;

  // parse state
  rcp_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0]   byte_pos_r, byte_pos_nxt;
  logic [LW-1:0]   packet_len_r, packet_len_nxt;
  logic [LW-1:0]   cookie_count_r, cookie_count_nxt;
  logic            key_matching_r, key_matching_nxt;
  logic            value_open_r, value_open_nxt;

  // output register and skid entry
  rcp_pkg::out_item_t out_r, skid_r, res;
  logic               out_valid_r, skid_valid_r;
  logic               res_valid;

  logic       in_acc, out_pop;
  logic [7:0] b;
  logic [3:0] used_k;
  logic [7:0] key_c;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign in_acc       = in_ch.valid && !skid_valid_r;
  assign out_pop      = out_valid_r && out_ch.ready;
  assign b            = in_ch.data_byte;
  assign used_k       = (key_len_r > KMAX) ? KMAX : key_len_r;
  assign key_c        = key_chars_r[cookie_count_r[KIDX_W-1:0]*8 +: 8];

  function automatic rcp_pkg::out_item_t make_verdict(
    input rcp_pkg::verdict_t v,
    input logic [LW-1:0]     cc,
    input logic              vo,
    input logic [3:0]        k
  );
    rcp_pkg::out_item_t r;
    r         = '0;
    r.kind    = 1'b1;
    r.verdict = v;
    if (v == rcp_pkg::VERD_OK) begin
      r.cookie_len = cc;
      if (vo) begin
        r.value_found = 1'b1;
        r.value_len   = cc - LW'(k) - LW'(1);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      key_chars_r <= '0;
      key_len_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rcp_pkg::CFG_ENABLE:    enable_r    <= cfg_ch.data[0];
        rcp_pkg::CFG_KEY_CHARS: key_chars_r <= cfg_ch.data[KEY_BYTES*8-1:0];
        rcp_pkg::CFG_KEY_LEN:   key_len_r   <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    byte_pos_nxt     = byte_pos_r;
    packet_len_nxt   = packet_len_r;
    cookie_count_nxt = cookie_count_r;
    key_matching_nxt = key_matching_r;
    value_open_nxt   = value_open_r;
    res_valid        = 1'b0;
    res              = '0;
    if (in_acc) begin
      if (in_ch.first) begin
        // restart the parse
        phase_nxt        = rcp_pkg::PH_IDLE;
        byte_pos_nxt     = '0;
        packet_len_nxt   = '0;
        cookie_count_nxt = '0;
        key_matching_nxt = 1'b1;
        value_open_nxt   = 1'b0;
        if (!enable_r) begin
          res_valid = 1'b1;
          res       = make_verdict(rcp_pkg::VERD_DISABLED, '0, 1'b0, used_k);
          phase_nxt = rcp_pkg::PH_DONE;
        end else if (b != rcp_pkg::TPKT_VERSION) begin
          res_valid = 1'b1;
          res       = make_verdict(rcp_pkg::VERD_NOT_TPKT, '0, 1'b0, used_k);
          phase_nxt = rcp_pkg::PH_DONE;
        end else begin
          phase_nxt    = rcp_pkg::PH_HDR;
          byte_pos_nxt = LW'(1);
        end
      end else begin
        unique case (phase_r)
          rcp_pkg::PH_HDR: begin
            if (byte_pos_r == LW'(1)) begin
              if (b != 8'd0) begin
                res_valid = 1'b1;
                res       = make_verdict(rcp_pkg::VERD_BAD_RSV, '0, 1'b0, used_k);
                phase_nxt = rcp_pkg::PH_DONE;
              end else begin
                byte_pos_nxt = byte_pos_r + LW'(1);
              end
            end else if (byte_pos_r == LW'(2)) begin
              packet_len_nxt = {b, 8'h00};
              byte_pos_nxt   = byte_pos_r + LW'(1);
            end else begin
              packet_len_nxt = packet_len_r | LW'(b);
              if ((packet_len_r | LW'(b)) < rcp_pkg::MIN_PKT_LEN) begin
                res_valid = 1'b1;
                res       = make_verdict(rcp_pkg::VERD_TOO_SHORT, '0, 1'b0, used_k);
                phase_nxt = rcp_pkg::PH_DONE;
              end else begin
                phase_nxt    = rcp_pkg::PH_TAG;
                byte_pos_nxt = byte_pos_r + LW'(1);
              end
            end
          end
          rcp_pkg::PH_TAG: begin
            if (byte_pos_r >= rcp_pkg::TAG_FIRST &&
                rcp_pkg::lower_ascii(b) !=
                rcp_pkg::tag_char(3'(byte_pos_r - rcp_pkg::TAG_FIRST))) begin
              res_valid = 1'b1;
              res       = make_verdict(rcp_pkg::VERD_NO_TAG, '0, 1'b0, used_k);
              phase_nxt = rcp_pkg::PH_DONE;
            end else begin
              if (byte_pos_r == rcp_pkg::TAG_LAST) phase_nxt = rcp_pkg::PH_SKIP;
              byte_pos_nxt = byte_pos_r + LW'(1);
            end
          end
          rcp_pkg::PH_SKIP, rcp_pkg::PH_SCAN: begin
            // last byte of the packet leaves no room for CR LF
            if (({1'b0, byte_pos_r} + (LW+1)'(1)) >= {1'b0, packet_len_r}) begin
              res_valid = 1'b1;
              res       = make_verdict(rcp_pkg::VERD_BAD_COOKIE, '0, 1'b0, used_k);
              phase_nxt = rcp_pkg::PH_DONE;
            end else begin
              byte_pos_nxt = byte_pos_r + LW'(1);
              if (!(phase_r == rcp_pkg::PH_SKIP && b == rcp_pkg::CHAR_SPACE)) begin
                phase_nxt = rcp_pkg::PH_SCAN;
                if (b == rcp_pkg::CHAR_CR) begin
                  phase_nxt = rcp_pkg::PH_LF;
                end else begin
                  res_valid       = 1'b1;
                  res.cookie_byte = b;
                  if (cookie_count_r < LW'(used_k)) begin
                    if (rcp_pkg::lower_ascii(b) != rcp_pkg::lower_ascii(key_c))
                      key_matching_nxt = 1'b0;
                  end else if (cookie_count_r == LW'(used_k)) begin
                    if (key_matching_r && b == rcp_pkg::CHAR_EQ) value_open_nxt = 1'b1;
                  end else begin
                    res.in_value = value_open_r;
                  end
                  cookie_count_nxt = cookie_count_r + LW'(1);
                end
              end
            end
          end
          rcp_pkg::PH_LF: begin
            res_valid = 1'b1;
            res       = make_verdict((b == rcp_pkg::CHAR_LF) ? rcp_pkg::VERD_OK
                                                             : rcp_pkg::VERD_BAD_COOKIE,
                                     cookie_count_r, value_open_r, used_k);
            phase_nxt = rcp_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rcp_pkg::PH_IDLE;
      byte_pos_r     <= '0;
      packet_len_r   <= '0;
      cookie_count_r <= '0;
      key_matching_r <= 1'b1;
      value_open_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      byte_pos_r     <= byte_pos_nxt;
      packet_len_r   <= packet_len_nxt;
      cookie_count_r <= cookie_count_nxt;
      key_matching_r <= key_matching_nxt;
      value_open_r   <= value_open_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && res_valid) begin
      if (!out_valid_r || out_pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.cookie_byte = out_r.cookie_byte;
  assign out_ch.in_value    = out_r.in_value;
  assign out_ch.verdict     = out_r.verdict;
  assign out_ch.cookie_len  = out_r.cookie_len;
  assign out_ch.value_found = out_r.value_found;
  assign out_ch.value_len   = out_r.value_len;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry lost while output stalled");

  a_value_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    value_open_r |-> key_matching_r)
    else $error("value opened without key match");

  a_byte_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.kind) |-> (out_r.verdict == rcp_pkg::VERD_OK &&
                                      out_r.cookie_len == '0))
    else $error("cookie byte result carries verdict fields");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the RDP cookie pre-read parser top level.
// Depends on rcp_pkg and the channel interfaces in rcp_ifs; drives random connection streams
// and checks every result against a built-in byte-wise model or a fixed directed result.
`timescale 1ns / 1ps

module testbench;

  localparam logic [55:0] TAG_LOWER = "cookie:";

  typedef struct {
    bit                            is_reg;
    logic [rcp_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [63:0]                   reg_val;
    logic [7:0]                    octet;
    bit                            lead;
    bit                            typed;
    bit                            typed_has;
    rcp_pkg::out_item_t            typed_res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rcp_in_if  in_ch ();
  rcp_out_if out_ch ();
  rcp_cfg_if cfg_ch ();

  rdp_cookie_preread_parser_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Parse model state and register copies
  rcp_pkg::phase_t ps;
  int unsigned     pos;
  int unsigned     plen;
  logic [15:0]     ncookie;
  bit              key_ok;
  bit              val_open;
  bit              cfg_en;
  logic [63:0]     cfg_key;
  logic [3:0]      cfg_klen;

  rcp_pkg::out_item_t results_due[$];
  logic [7:0]         stream_bytes[$];
  stim_row_t          plan[$];

  int unsigned mismatches;
  int unsigned parsed_bytes;
  int unsigned dropped_bytes;
  int unsigned verdicts_total;
  int unsigned cookie_bytes_total;
  bit          calm;

  always #10 clk = ~clk;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int unsigned key_span();
    return (cfg_klen > rcp_pkg::KEY_BYTES_DEF) ? rcp_pkg::KEY_BYTES_DEF : cfg_klen;
  endfunction

  function automatic void restart_parse();
    ps       = rcp_pkg::PH_IDLE;
    pos      = 0;
    plen     = 0;
    ncookie  = '0;
    key_ok   = 1'b1;
    val_open = 1'b0;
  endfunction

  function automatic rcp_pkg::out_item_t verdict_of(input rcp_pkg::verdict_t v);
    rcp_pkg::out_item_t r;
    logic [15:0]        k16;
    r   = '0;
    k16 = 16'(key_span());
    r.kind    = 1'b1;
    r.verdict = v;
    if (v == rcp_pkg::VERD_OK) begin
      r.cookie_len = ncookie;
      if (val_open) begin
        r.value_found = 1'b1;
        r.value_len   = ncookie - k16 - 16'd1;
      end
    end
    ps = rcp_pkg::PH_DONE;
    return r;
  endfunction

  function automatic rcp_pkg::out_item_t cookie_of(input logic [7:0] b);
    rcp_pkg::out_item_t r;
    int unsigned        k;
    logic [7:0]         kc;
    r = '0;
    k = key_span();
    if (ncookie < k) begin
      kc = cfg_key[8*ncookie +: 8];
      if (fold_case(b) != fold_case(kc)) key_ok = 1'b0;
    end else if (ncookie == k) begin
      if (key_ok && b == rcp_pkg::CHAR_EQ) val_open = 1'b1;
    end else begin
      r.in_value = val_open;
    end
    ncookie = ncookie + 16'd1;
    r.cookie_byte = b;
    return r;
  endfunction

  // Advance the parse by one byte; returns 1 when the byte produces a result
  function automatic bit step_cookie_parse(input logic [7:0] b, input bit lead,
                                           output rcp_pkg::out_item_t r,
                                           output bit skipped);
    int unsigned idx;
    r = '0;
    skipped = 1'b0;
    if (lead) begin
      restart_parse();
      if (!cfg_en) begin
        r = verdict_of(rcp_pkg::VERD_DISABLED);
        return 1'b1;
      end
      if (b != rcp_pkg::TPKT_VERSION) begin
        r = verdict_of(rcp_pkg::VERD_NOT_TPKT);
        return 1'b1;
      end
      ps  = rcp_pkg::PH_HDR;
      pos = 1;
      return 1'b0;
    end
    case (ps)
      rcp_pkg::PH_HDR: begin
        if (pos == 1) begin
          if (b != 8'd0) begin
            r = verdict_of(rcp_pkg::VERD_BAD_RSV);
            return 1'b1;
          end
        end else if (pos == 2) begin
          plen = 32'({b, 8'd0});
        end else begin
          plen = plen | 32'(b);
          if (plen < rcp_pkg::MIN_PKT_LEN) begin
            r = verdict_of(rcp_pkg::VERD_TOO_SHORT);
            return 1'b1;
          end
          ps = rcp_pkg::PH_TAG;
        end
        pos++;
        return 1'b0;
      end
      rcp_pkg::PH_TAG: begin
        if (pos >= rcp_pkg::TAG_FIRST) begin
          idx = pos - rcp_pkg::TAG_FIRST;
          if (fold_case(b) != TAG_LOWER[8*(6-idx) +: 8]) begin
            r = verdict_of(rcp_pkg::VERD_NO_TAG);
            return 1'b1;
          end
          if (pos == rcp_pkg::TAG_LAST) ps = rcp_pkg::PH_SKIP;
        end
        pos++;
        return 1'b0;
      end
      rcp_pkg::PH_SKIP, rcp_pkg::PH_SCAN: begin
        // no room left for CR and LF inside the packet
        if (pos + 1 >= plen) begin
          r = verdict_of(rcp_pkg::VERD_BAD_COOKIE);
          return 1'b1;
        end
        pos++;
        if (ps == rcp_pkg::PH_SKIP) begin
          if (b == rcp_pkg::CHAR_SPACE) return 1'b0;
          ps = rcp_pkg::PH_SCAN;
        end
        if (b == rcp_pkg::CHAR_CR) begin
          ps = rcp_pkg::PH_LF;
          return 1'b0;
        end
        r = cookie_of(b);
        return 1'b1;
      end
      rcp_pkg::PH_LF: begin
        r = verdict_of(b == rcp_pkg::CHAR_LF ? rcp_pkg::VERD_OK : rcp_pkg::VERD_BAD_COOKIE);
        return 1'b1;
      end
      default: begin
        skipped = 1'b1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] cookie_char();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((fold_case(c) >= "a" && fold_case(c) <= "z") && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [63:0] random_key();
    logic [63:0] kv;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0:       kv[8*i +: 8] = 8'($urandom_range("A", "Z"));
        1:       kv[8*i +: 8] = 8'($urandom_range("0", "9"));
        default: kv[8*i +: 8] = 8'($urandom_range("a", "z"));
      endcase
    end
    return kv;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit lead);
    stim_row_t row;
    row = '{default: '0};
    row.octet = b;
    row.lead  = lead;
    plan.push_back(row);
  endfunction

  function automatic void add_quiet(input logic [7:0] b, input bit lead);
    add_byte(b, lead);
    plan[$].typed = 1'b1;
  endfunction

  function automatic void add_verdict(input logic [7:0] b, input bit lead,
                                      input rcp_pkg::verdict_t v);
    rcp_pkg::out_item_t r;
    r = '0;
    r.kind    = 1'b1;
    r.verdict = v;
    add_byte(b, lead);
    plan[$].typed     = 1'b1;
    plan[$].typed_has = 1'b1;
    plan[$].typed_res = r;
  endfunction

  function automatic void add_reg(input logic [rcp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  // Hold the sender until every awaited result is back, then let the parser settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rcp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      rcp_pkg::CFG_ENABLE:    cfg_en   = val[0];
      rcp_pkg::CFG_KEY_CHARS: cfg_key  = val;
      rcp_pkg::CFG_KEY_LEN:   cfg_klen = val[3:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] octet, input bit lead, input bit typed,
                           input bit typed_has, input rcp_pkg::out_item_t typed_res);
    int unsigned        gap;
    rcp_pkg::out_item_t r;
    bit                 has;
    bit                 skipped;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= octet;
    in_ch.first     <= lead;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = step_cookie_parse(octet, lead, r, skipped);
    if (skipped) dropped_bytes++;
    else parsed_bytes++;
    if (typed) begin
      has = typed_has;
      r   = typed_res;
    end
    if (has) begin
      results_due.push_back(r);
      if (r.kind) verdicts_total++;
      else cookie_bytes_total++;
    end
  endtask

  // Build one connection opening with random content into stream_bytes
  task automatic make_request();
    logic [7:0] body[$];
    int         sp;
    int         k;
    int         nval;
    int         need;
    int         plen_req;
    body = {};
    stream_bytes = {};
    sp = $urandom_range(0, 3);
    k  = key_span();
    if (k > 0 && $urandom_range(0, 2) != 0) begin
      for (int i = 0; i < k; i++) body.push_back(flip_case(cfg_key[8*i +: 8]));
      if ($urandom_range(0, 5) == 0) body[$urandom_range(0, k - 1)] ^= 8'h01;
      body.push_back($urandom_range(0, 7) == 0 ? cookie_char() : rcp_pkg::CHAR_EQ);
      nval = $urandom_range(0, 8);
    end else begin
      nval = $urandom_range(0, 12);
    end
    repeat (nval) body.push_back(cookie_char());
    need = 20 + sp + body.size();
    case ($urandom_range(0, 9))
      0:       plen_req = need;
      1:       plen_req = need - $urandom_range(1, 3);
      2:       plen_req = $urandom_range(need, 65535);
      3:       plen_req = 65535;
      default: plen_req = need + $urandom_range(0, 40);
    endcase
    stream_bytes.push_back(rcp_pkg::TPKT_VERSION);
    stream_bytes.push_back(8'd0);
    stream_bytes.push_back(plen_req[15:8]);
    stream_bytes.push_back(plen_req[7:0]);
    repeat (7) stream_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 7; i++) stream_bytes.push_back(flip_case(TAG_LOWER[8*(6-i) +: 8]));
    repeat (sp) stream_bytes.push_back(rcp_pkg::CHAR_SPACE);
    foreach (body[i]) stream_bytes.push_back(body[i]);
    stream_bytes.push_back(rcp_pkg::CHAR_CR);
    stream_bytes.push_back(rcp_pkg::CHAR_LF);
  endtask

  task automatic send_connection();
    int                 pick;
    int                 cut;
    bit                 noisy;
    bit                 lead;
    rcp_pkg::out_item_t none;
    none  = '0;
    noisy = 1'b0;
    calm  = ($urandom_range(0, 4) == 0);
    pick  = $urandom_range(0, 99);
    if (pick < 90) begin
      make_request();
      if (pick >= 70 && pick < 80) begin
        stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick >= 80) begin
        cut = $urandom_range(1, stream_bytes.size() - 1);
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
    end else begin
      noisy = 1'b1;
      stream_bytes = {};
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // trailing bytes are dropped by the parser if the verdict came before them, else parsed
    if (!noisy && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (stream_bytes[i]) begin
      lead = noisy ? ($urandom_range(0, 7) == 0) : (i == 0);
      push_byte(stream_bytes[i], lead, 1'b0, 1'b0, none);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    rcp_pkg::out_item_t got;
    rcp_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind        = out_ch.kind;
      got.cookie_byte = out_ch.cookie_byte;
      got.in_value    = out_ch.in_value;
      got.verdict     = out_ch.verdict;
      got.cookie_len  = out_ch.cookie_len;
      got.value_found = out_ch.value_found;
      got.value_len   = out_ch.value_len;
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result kind=%0d byte=%h verdict=%0d", $realtime,
                   got.kind, got.cookie_byte, got.verdict);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind || got.cookie_byte !== want.cookie_byte ||
            got.in_value !== want.in_value || got.verdict !== want.verdict ||
            got.cookie_len !== want.cookie_len || got.value_found !== want.value_found ||
            got.value_len !== want.value_len) begin
          if (mismatches < 10) begin
            $display("%0t: expected kind=%0d byte=%h iv=%0d vd=%0d clen=%0d vf=%0d vlen=%0d",
                     $realtime, want.kind, want.cookie_byte, want.in_value, want.verdict,
                     want.cookie_len, want.value_found, want.value_len);
            $display("%0t: actual   kind=%0d byte=%h iv=%0d vd=%0d clen=%0d vf=%0d vlen=%0d",
                     $realtime, got.kind, got.cookie_byte, got.in_value, got.verdict,
                     got.cookie_len, got.value_found, got.value_len);
          end
          mismatches++;
        end
      end
    end
  end

  // Result receiver: random stalls per result, with calm stretches
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d results still awaited", results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [63:0] key_val;
    logic [3:0]  klen_val;
    bit          en_val;
    int unsigned quota;
    int unsigned start_count;
    int unsigned since_drain;

    clk = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.first     <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= rcp_pkg::CFG_ENABLE;
    cfg_ch.data     <= '0;
    mismatches = 0;
    parsed_bytes = 0;
    dropped_bytes = 0;
    verdicts_total = 0;
    cookie_bytes_total = 0;
    calm = 1'b0;
    cfg_en = 1'b0;
    cfg_key = '0;
    cfg_klen = '0;
    restart_parse();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: drops, every header decline, and the shortest legal packet
    add_quiet(8'h55, 1'b0);
    add_verdict(rcp_pkg::TPKT_VERSION, 1'b1, rcp_pkg::VERD_DISABLED);
    add_quiet(8'hff, 1'b0);
    add_reg(rcp_pkg::CFG_ENABLE, 64'd1);
    add_verdict(8'h00, 1'b1, rcp_pkg::VERD_NOT_TPKT);
    add_byte(rcp_pkg::TPKT_VERSION, 1'b1);
    add_verdict(8'hff, 1'b0, rcp_pkg::VERD_BAD_RSV);
    add_byte(rcp_pkg::TPKT_VERSION, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_verdict(8'd20, 1'b0, rcp_pkg::VERD_TOO_SHORT);
    add_byte(rcp_pkg::TPKT_VERSION, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'd21, 1'b0);
    for (int i = 0; i < 7; i++) add_byte((i % 2) ? 8'h00 : 8'hff, 1'b0);
    for (int i = 0; i < 7; i++) add_byte(TAG_LOWER[8*(6-i) +: 8] & 8'hdf | 8'(i == 6) << 5,
                                         1'b0);
    add_byte(rcp_pkg::CHAR_CR, 1'b0);
    add_verdict(rcp_pkg::CHAR_LF, 1'b0, rcp_pkg::VERD_OK);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_byte(plan[i].octet, plan[i].lead, plan[i].typed, plan[i].typed_has,
                     plan[i].typed_res);
    end

    // Random part over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      key_val  = random_key();
      en_val   = 1'b1;
      klen_val = 4'($urandom_range(0, 15));
      case (ph)
        0: klen_val = 4'($urandom_range(1, 8));
        1: begin key_val = '0; klen_val = 4'd3; end
        2: begin key_val = '1; klen_val = 4'd8; end
        3: klen_val = 4'd15;
        4: en_val = 1'b0;
        5: klen_val = 4'd0;
        7: klen_val = 4'd1;
        default: ;
      endcase
      write_reg(rcp_pkg::CFG_KEY_CHARS, key_val);
      write_reg(rcp_pkg::CFG_KEY_LEN, {60'd0, klen_val});
      write_reg(rcp_pkg::CFG_ENABLE, {63'd0, en_val});
      quota = en_val ? 140 : 30;
      start_count = parsed_bytes + dropped_bytes;
      since_drain = 0;
      while (parsed_bytes + dropped_bytes - start_count < quota) begin
        send_connection();
        since_drain++;
        if (since_drain == 12) begin
          drain_results();
          since_drain = 0;
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Parsed %0d bytes (%0d more dropped) across 8 register settings;",
             parsed_bytes, dropped_bytes);
    $display("checked %0d cookie bytes and %0d verdicts, %0d mismatches.",
             cookie_bytes_total, verdicts_total, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rcp_pkg.sv
rtl/rcp_ifs.sv
rtl/rdp_cookie_preread_parser_unit.sv
verif/testbench.sv
